@@ design/dmrc_pkg.sv @@
// Shared constants and types for the direct-mapped read cache.
// Used by every module of the block but dmrc_ram; has no dependencies of its own.
package dmrc_pkg;

    localparam int NUM_SETS    = 8;
    localparam int LINE_BYTES  = 32;
    localparam int ADDR_W      = 32;
    localparam int BYTE_W      = 8;
    localparam int CNT_W       = 32;
    localparam int OFFSET_W    = $clog2(LINE_BYTES);
    localparam int SET_W       = $clog2(NUM_SETS);
    localparam int TAG_W       = ADDR_W - SET_W - OFFSET_W;
    localparam int DATA_DEPTH  = NUM_SETS * LINE_BYTES;
    localparam int DADDR_W     = SET_W + OFFSET_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic CMD_READ = 1'b0;
    localparam logic CMD_FILL = 1'b1;

    typedef enum logic [1:0] {
        KIND_HIT      = 2'd0,
        KIND_FILLED   = 2'd1,
        KIND_FILL_REQ = 2'd2,
        KIND_REJECT   = 2'd3
    } kind_t;

    // One operation for the back end: an optional data-store write, an optional
    // data-store read and, where has_result is set, the result to deliver.
    typedef struct packed {
        logic                wr_en;
        logic [DADDR_W-1:0]  wr_addr;
        logic [BYTE_W-1:0]   wr_data;
        logic                has_result;
        logic                rd_en;
        logic                rd_bypass;
        logic [DADDR_W-1:0]  rd_addr;
        kind_t               kind;
        logic [ADDR_W-1:0]   fill_address;
        logic [CNT_W-1:0]    hits;
        logic [CNT_W-1:0]    misses;
    } op_t;

endpackage

@@ design/dmrc_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
module dmrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/dmrc_front.sv @@
// Front end of the cache: accepts transfers, holds tags, valid bits, fill state
// and counters, and turns each transfer into an operation for the back end.
// Depends on dmrc_pkg.
module dmrc_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_cmd,
    input  logic [dmrc_pkg::ADDR_W-1:0] s_address,
    input  logic [dmrc_pkg::OFFSET_W-1:0] s_fill_index,
    input  logic [dmrc_pkg::BYTE_W-1:0] s_fill_byte,
    input  logic                        q_full,
    output logic                        q_push,
    output dmrc_pkg::op_t               q_op
);
    import dmrc_pkg::*;

    logic [NUM_SETS-1:0] valid_reg, valid_next;
    logic [TAG_W-1:0]    tag_reg [NUM_SETS];
    logic                pending_reg, pending_next;
    logic [ADDR_W-1:0]   pend_addr_reg, pend_addr_next;
    logic [OFFSET_W-1:0] next_fill_reg, next_fill_next;
    logic [CNT_W-1:0]    hits_reg, hits_next;
    logic [CNT_W-1:0]    misses_reg, misses_next;
    logic                tag_we;

    logic                accept;
    logic [SET_W-1:0]    set_idx;
    logic [TAG_W-1:0]    addr_tag;
    logic [OFFSET_W-1:0] addr_off;
    logic                hit;
    logic [SET_W-1:0]    pend_set;
    logic [OFFSET_W-1:0] pend_off;

    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;
    assign set_idx  = s_address[OFFSET_W +: SET_W];
    assign addr_tag = s_address[ADDR_W-1 -: TAG_W];
    assign addr_off = s_address[OFFSET_W-1:0];
    assign hit      = valid_reg[set_idx] && (tag_reg[set_idx] == addr_tag);
    assign pend_set = pend_addr_reg[OFFSET_W +: SET_W];
    assign pend_off = pend_addr_reg[OFFSET_W-1:0];

    always_comb begin
        valid_next     = valid_reg;
        pending_next   = pending_reg;
        pend_addr_next = pend_addr_reg;
        next_fill_next = next_fill_reg;
        hits_next      = hits_reg;
        misses_next    = misses_reg;
        tag_we         = 1'b0;
        q_push         = 1'b0;
        q_op           = '0;
        if (accept) begin
            if (s_cmd == CMD_READ) begin
                q_push        = 1'b1;
                q_op.has_result = 1'b1;
                if (pending_reg) begin
                    q_op.kind = KIND_REJECT;
                end else if (hit) begin
                    hits_next    = hits_reg + 1'b1;
                    q_op.kind    = KIND_HIT;
                    q_op.rd_en   = 1'b1;
                    q_op.rd_addr = {set_idx, addr_off};
                end else begin
                    misses_next         = misses_reg + 1'b1;
                    valid_next[set_idx] = 1'b0;
                    pending_next        = 1'b1;
                    pend_addr_next      = s_address;
                    next_fill_next      = '0;
                    q_op.kind           = KIND_FILL_REQ;
                    q_op.fill_address   = {s_address[ADDR_W-1:OFFSET_W], OFFSET_W'(0)};
                end
            end else if (pending_reg && (s_fill_index == next_fill_reg)) begin
                // Fill bytes travel through the queue so that they land after
                // any earlier read of the same line.
                q_push         = 1'b1;
                q_op.wr_en     = 1'b1;
                q_op.wr_addr   = {pend_set, next_fill_reg};
                q_op.wr_data   = s_fill_byte;
                next_fill_next = next_fill_reg + 1'b1;
                if (next_fill_reg == OFFSET_W'(LINE_BYTES - 1)) begin
                    valid_next[pend_set] = 1'b1;
                    tag_we               = 1'b1;
                    pending_next         = 1'b0;
                    next_fill_next       = '0;
                    q_op.has_result      = 1'b1;
                    q_op.kind            = KIND_FILLED;
                    q_op.rd_en           = 1'b1;
                    q_op.rd_addr         = {pend_set, pend_off};
                    q_op.rd_bypass       = (pend_off == next_fill_reg);
                end
            end
        end
        q_op.hits   = hits_next;
        q_op.misses = misses_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            pending_reg   <= 1'b0;
            pend_addr_reg <= '0;
            next_fill_reg <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
        end else begin
            valid_reg     <= valid_next;
            pending_reg   <= pending_next;
            pend_addr_reg <= pend_addr_next;
            next_fill_reg <= next_fill_next;
            hits_reg      <= hits_next;
            misses_reg    <= misses_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (tag_we) begin
            tag_reg[pend_set] <= pend_addr_reg[ADDR_W-1 -: TAG_W];
        end
    end

endmodule

@@ design/dmrc_queue.sv @@
// Short FIFO of operations between the front and back ends of the cache.
// Depends on dmrc_pkg.
module dmrc_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  dmrc_pkg::op_t push_op,
    input  logic          pop,
    output dmrc_pkg::op_t head_op,
    output logic          full,
    output logic          empty
);
    import dmrc_pkg::*;

    op_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head_op = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

@@ design/dmrc_back.sv @@
// Back end of the cache: carries out queued operations on the line data store
// and drives the result channel through an output register.
// Depends on dmrc_pkg and dmrc_ram.
module dmrc_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_empty,
    input  dmrc_pkg::op_t               q_op,
    output logic                        q_pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_kind,
    output logic [dmrc_pkg::BYTE_W-1:0] m_read_byte,
    output logic [dmrc_pkg::ADDR_W-1:0] m_fill_address,
    output logic [dmrc_pkg::CNT_W-1:0]  m_hits,
    output logic [dmrc_pkg::CNT_W-1:0]  m_misses
);
    import dmrc_pkg::*;

    logic              s1_valid_reg, s1_valid_next;
    op_t               s1_op_reg;
    logic [BYTE_W-1:0] rdata;
    logic [BYTE_W-1:0] result_byte;
    logic              out_load;
    logic              s1_free;

    logic              m_valid_reg, m_valid_next;
    logic [1:0]        m_kind_reg;
    logic [BYTE_W-1:0] m_read_byte_reg;
    logic [ADDR_W-1:0] m_fill_address_reg;
    logic [CNT_W-1:0]  m_hits_reg;
    logic [CNT_W-1:0]  m_misses_reg;

    assign out_load = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s1_free  = !s1_valid_reg || out_load;
    assign q_pop    = !q_empty && s1_free;

    dmrc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DATA_DEPTH)
    ) u_data_ram (
        .aclk  (aclk),
        .we    (q_pop && q_op.wr_en),
        .waddr (q_op.wr_addr),
        .wdata (q_op.wr_data),
        .re    (q_pop && q_op.rd_en),
        .raddr (q_op.rd_addr),
        .rdata (rdata)
    );

    // The final fill byte may be the very byte requested; the RAM returns the
    // old contents on a same-cycle write, so that byte is taken from the operation.
    always_comb begin
        result_byte = '0;
        if (s1_op_reg.rd_en) begin
            result_byte = s1_op_reg.rd_bypass ? s1_op_reg.wr_data : rdata;
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (q_pop) begin
            s1_valid_next = q_op.has_result;
        end else if (out_load) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            s1_op_reg <= q_op;
        end
        if (out_load) begin
            m_kind_reg         <= s1_op_reg.kind;
            m_read_byte_reg    <= result_byte;
            m_fill_address_reg <= s1_op_reg.fill_address;
            m_hits_reg         <= s1_op_reg.hits;
            m_misses_reg       <= s1_op_reg.misses;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_read_byte    = m_read_byte_reg;
    assign m_fill_address = m_fill_address_reg;
    assign m_hits         = m_hits_reg;
    assign m_misses       = m_misses_reg;

endmodule

@@ design/direct_mapped_read_cache.sv @@
// Read-only direct-mapped byte cache, 8 sets of 32-byte lines, with a front end
// that classifies transfers and a back end that drives the line data store.
// Depends on dmrc_pkg, dmrc_front, dmrc_queue and dmrc_back.
//
// One input transfer is taken per cycle while the four-entry operation queue
// has room; a result passes through the queue entry, the registered read of
// the line data RAM and the output register, and back-pressure on the result
// channel fills the queue and then stalls the input. A miss answers at once
// with a line-aligned fill request; the line then needs 32 fill transfers,
// one per cycle at best, and the last one yields the requested byte. Reads
// arriving while a fill is outstanding are answered as rejected, and fill bytes
// that are unexpected or out of order are dropped without a result. No clearing
// pass follows reset.
module direct_mapped_read_cache (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_cmd,
    input  logic [dmrc_pkg::ADDR_W-1:0]   s_address,
    input  logic [dmrc_pkg::OFFSET_W-1:0] s_fill_index,
    input  logic [dmrc_pkg::BYTE_W-1:0]   s_fill_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_kind,
    output logic [dmrc_pkg::BYTE_W-1:0]   m_read_byte,
    output logic [dmrc_pkg::ADDR_W-1:0]   m_fill_address,
    output logic [dmrc_pkg::CNT_W-1:0]    m_hits,
    output logic [dmrc_pkg::CNT_W-1:0]    m_misses
);
    import dmrc_pkg::*;

    logic q_push, q_pop, q_full, q_empty;
    op_t  push_op, head_op;

    dmrc_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_address    (s_address),
        .s_fill_index (s_fill_index),
        .s_fill_byte  (s_fill_byte),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_op         (push_op)
    );

    dmrc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_op (push_op),
        .pop     (q_pop),
        .head_op (head_op),
        .full    (q_full),
        .empty   (q_empty)
    );

    dmrc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_empty        (q_empty),
        .q_op           (head_op),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_read_byte    (m_read_byte),
        .m_fill_address (m_fill_address),
        .m_hits         (m_hits),
        .m_misses       (m_misses)
    );

endmodule

@@ test/cache_reply_checker.sv @@
`timescale 1ns / 1ps
// Checker for the direct-mapped read cache: watches both channels, predicts each result
// from its own copy of the cache state and compares it with what the block returns.
// Depends on dmrc_pkg for widths, command codes and result kinds.
module cache_reply_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          s_cmd,
    input  logic [dmrc_pkg::ADDR_W-1:0]   s_address,
    input  logic [dmrc_pkg::OFFSET_W-1:0] s_fill_index,
    input  logic [dmrc_pkg::BYTE_W-1:0]   s_fill_byte,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [1:0]                    m_kind,
    input  logic [dmrc_pkg::BYTE_W-1:0]   m_read_byte,
    input  logic [dmrc_pkg::ADDR_W-1:0]   m_fill_address,
    input  logic [dmrc_pkg::CNT_W-1:0]    m_hits,
    input  logic [dmrc_pkg::CNT_W-1:0]    m_misses,
    output int                            replies_due,
    output int                            fault_count
);
    import dmrc_pkg::*;

    typedef struct {
        kind_t             kind;
        logic [BYTE_W-1:0] read_byte;
        logic [ADDR_W-1:0] fill_address;
        logic [CNT_W-1:0]  hits;
        logic [CNT_W-1:0]  misses;
    } cache_reply_t;

    logic [NUM_SETS-1:0] line_loaded;
    logic [TAG_W-1:0]    line_tag_copy [NUM_SETS];
    logic [BYTE_W-1:0]   line_data [DATA_DEPTH];
    logic                fill_open;
    logic [ADDR_W-1:0]   fill_addr_held;
    int                  fill_pos;
    logic [CNT_W-1:0]    hit_total;
    logic [CNT_W-1:0]    miss_total;
    int                  fault_total;
    cache_reply_t        expected_replies [$];

    // Advances the cache copy by one accepted transfer; returns 1 when it causes a result.
    function automatic bit predict_cache_step(
        input  logic                cmd,
        input  logic [ADDR_W-1:0]   addr,
        input  logic [OFFSET_W-1:0] fidx,
        input  logic [BYTE_W-1:0]   fbyte,
        output cache_reply_t        reply
    );
        logic [SET_W-1:0]    set_idx;
        logic [TAG_W-1:0]    tag_bits;
        logic [OFFSET_W-1:0] off;
        reply.kind         = KIND_HIT;
        reply.read_byte    = '0;
        reply.fill_address = '0;
        if (cmd == CMD_READ) begin
            set_idx  = addr[OFFSET_W +: SET_W];
            tag_bits = addr[ADDR_W-1 -: TAG_W];
            off      = addr[OFFSET_W-1:0];
            if (fill_open) begin
                reply.kind = KIND_REJECT;
            end else if (line_loaded[set_idx] && line_tag_copy[set_idx] == tag_bits) begin
                hit_total       = hit_total + 1'b1;
                reply.read_byte = line_data[{set_idx, off}];
            end else begin
                // The old line is dropped as soon as the fill request goes out.
                miss_total           = miss_total + 1'b1;
                line_loaded[set_idx] = 1'b0;
                fill_open            = 1'b1;
                fill_addr_held       = addr;
                fill_pos             = 0;
                reply.kind           = KIND_FILL_REQ;
                reply.fill_address   = {addr[ADDR_W-1:OFFSET_W], {OFFSET_W{1'b0}}};
            end
        end else begin
            if (!fill_open || int'(fidx) != fill_pos)
                return 1'b0;
            set_idx = fill_addr_held[OFFSET_W +: SET_W];
            line_data[{set_idx, fidx}] = fbyte;
            fill_pos = fill_pos + 1;
            if (fill_pos < LINE_BYTES)
                return 1'b0;
            line_loaded[set_idx]   = 1'b1;
            line_tag_copy[set_idx] = fill_addr_held[ADDR_W-1 -: TAG_W];
            fill_open              = 1'b0;
            fill_pos               = 0;
            reply.kind             = KIND_FILLED;
            reply.read_byte        = line_data[{set_idx, fill_addr_held[OFFSET_W-1:0]}];
        end
        reply.hits   = hit_total;
        reply.misses = miss_total;
        return 1'b1;
    endfunction

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, label, want, got);
            fault_total = fault_total + 1;
        end
    endtask

    always @(posedge aclk) begin : monitor
        cache_reply_t reply;
        cache_reply_t oldest;
        if (!aresetn) begin
            line_loaded    = '0;
            fill_open      = 1'b0;
            fill_addr_held = '0;
            fill_pos       = 0;
            hit_total      = '0;
            miss_total     = '0;
            fault_total    = 0;
            expected_replies.delete();
        end else begin
            if (s_valid && s_ready) begin
                if (predict_cache_step(s_cmd, s_address, s_fill_index, s_fill_byte, reply))
                    expected_replies.push_back(reply);
            end
            if (m_valid && m_ready) begin
                if (expected_replies.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got kind %0d",
                             $time, m_kind);
                    fault_total = fault_total + 1;
                end else begin
                    oldest = expected_replies.pop_front();
                    check_field("kind", 32'(oldest.kind), 32'(m_kind));
                    check_field("read_byte", 32'(oldest.read_byte), 32'(m_read_byte));
                    check_field("fill_address", oldest.fill_address, m_fill_address);
                    check_field("hits", oldest.hits, m_hits);
                    check_field("misses", oldest.misses, m_misses);
                end
            end
        end
        replies_due <= expected_replies.size();
        fault_count <= fault_total;
    end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// Top of the read cache testbench: clock, reset, stimulus and the verdict.
// Depends on dmrc_pkg, direct_mapped_read_cache and cache_reply_checker.
module testbench;
    import dmrc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 150;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS  = 235;

    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic                s_cmd          = CMD_READ;
    logic [ADDR_W-1:0]   s_address      = '0;
    logic [OFFSET_W-1:0] s_fill_index   = '0;
    logic [BYTE_W-1:0]   s_fill_byte    = '0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic [1:0]          m_kind;
    logic [BYTE_W-1:0]   m_read_byte;
    logic [ADDR_W-1:0]   m_fill_address;
    logic [CNT_W-1:0]    m_hits;
    logic [CNT_W-1:0]    m_misses;

    int replies_due;
    int fault_count;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    logic hold_request = 1'b0;
    logic hold_served  = 1'b0;
    int hold_left      = 0;

    // Which lines the stimulus believes are resident, so that fills follow each miss.
    logic [NUM_SETS-1:0] shadow_loaded = '0;
    logic [TAG_W-1:0]    shadow_tag [NUM_SETS];
    logic                line_fetching = 1'b0;
    logic [SET_W-1:0]    fetch_set;
    logic [TAG_W-1:0]    fetch_tag;
    int                  fetch_next;

    direct_mapped_read_cache uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_address      (s_address),
        .s_fill_index   (s_fill_index),
        .s_fill_byte    (s_fill_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_read_byte    (m_read_byte),
        .m_fill_address (m_fill_address),
        .m_hits         (m_hits),
        .m_misses       (m_misses)
    );

    cache_reply_checker reply_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_address      (s_address),
        .s_fill_index   (s_fill_index),
        .s_fill_byte    (s_fill_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_read_byte    (m_read_byte),
        .m_fill_address (m_fill_address),
        .m_hits         (m_hits),
        .m_misses       (m_misses),
        .replies_due    (replies_due),
        .fault_count    (fault_count)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off so that the block backs up.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_request && !hold_served) begin
            m_ready     <= 1'b0;
            hold_left   <= LONG_HOLD;
            hold_served <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_item(input logic cmd, input logic [ADDR_W-1:0] addr,
                             input logic [OFFSET_W-1:0] idx, input logic [BYTE_W-1:0] data);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_address    <= addr;
        s_fill_index <= idx;
        s_fill_byte  <= data;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic issue_read(input logic [ADDR_W-1:0] addr);
        logic [SET_W-1:0] set_idx;
        logic [TAG_W-1:0] tag_bits;
        set_idx  = addr[OFFSET_W +: SET_W];
        tag_bits = addr[ADDR_W-1 -: TAG_W];
        if (!line_fetching && !(shadow_loaded[set_idx] && shadow_tag[set_idx] == tag_bits)) begin
            shadow_loaded[set_idx] = 1'b0;
            line_fetching          = 1'b1;
            fetch_set              = set_idx;
            fetch_tag              = tag_bits;
            fetch_next             = 0;
        end
        send_item(CMD_READ, addr, OFFSET_W'($urandom), BYTE_W'($urandom));
    endtask

    task automatic issue_fill(input logic [OFFSET_W-1:0] idx, input logic [BYTE_W-1:0] data);
        if (line_fetching && int'(idx) == fetch_next) begin
            fetch_next = fetch_next + 1;
            if (fetch_next == LINE_BYTES) begin
                shadow_loaded[fetch_set] = 1'b1;
                shadow_tag[fetch_set]    = fetch_tag;
                line_fetching            = 1'b0;
            end
        end
        send_item(CMD_FILL, $urandom, idx, data);
    endtask

    // Tags lean towards a few values so that random reads also hit, and the extremes recur.
    function automatic logic [ADDR_W-1:0] random_address();
        logic [TAG_W-1:0] tag_bits;
        case ($urandom_range(4))
            0:       tag_bits = '0;
            1:       tag_bits = '1;
            2:       tag_bits = TAG_W'($urandom_range(3));
            default: tag_bits = TAG_W'($urandom);
        endcase
        return {tag_bits, SET_W'($urandom), OFFSET_W'($urandom)};
    endfunction

    task automatic random_item();
        int               pick;
        logic [SET_W-1:0] set_idx;
        pick = $urandom_range(99);
        if (line_fetching) begin
            if (pick < 85)
                issue_fill(OFFSET_W'(fetch_next), BYTE_W'($urandom));
            else if (pick < 93)
                issue_read(random_address());
            else
                issue_fill(OFFSET_W'(fetch_next + 1 + $urandom_range(LINE_BYTES - 2)),
                           BYTE_W'($urandom));
        end else begin
            if (pick < 75 && shadow_loaded != '0) begin
                do set_idx = SET_W'($urandom); while (!shadow_loaded[set_idx]);
                issue_read({shadow_tag[set_idx], set_idx, OFFSET_W'($urandom)});
            end else if (pick < 95) begin
                issue_read(random_address());
            end else begin
                issue_fill(OFFSET_W'($urandom), BYTE_W'($urandom));
            end
        end
    endtask

    // Stops offering and waits until every predicted result has been returned.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (replies_due != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 31;
        recv_idle_pct <= 73;

        // Directed: stray fill, miss at the top address, a rejected read, an out-of-order
        // fill, the full line with extreme bytes, a hit, then a miss that replaces the line.
        issue_fill(5'd0, 8'hA5);
        issue_read(32'hFFFF_FFFF);
        issue_read(32'h0000_0000);
        issue_fill(5'd1, 8'h00);
        for (int i = 0; i < LINE_BYTES; i++)
            issue_fill(OFFSET_W'(i),
                       (i == 0) ? 8'h00 : (i == LINE_BYTES - 1) ? 8'hFF : BYTE_W'($urandom));
        issue_read(32'hFFFF_FFE0);
        issue_read(32'h0000_00E5);

        for (int i = 0; i < PHASE_ITEMS; i++)
            random_item();
        wait_for_drain();

        send_idle_pct = 73;
        recv_idle_pct <= 31;
        for (int i = 0; i < PHASE_ITEMS; i++)
            random_item();
        wait_for_drain();

        send_idle_pct = 0;
        recv_idle_pct <= 0;
        hold_request  <= 1'b1;
        // Reads always answer, so a burst of them backs the block up behind the hold-off.
        for (int i = 0; i < 16; i++)
            issue_read(random_address());
        for (int i = 0; i < PHASE_ITEMS; i++)
            random_item();

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fault_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
